>>> hdl/vpfe_pkg.sv
package vpfe_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_PMS_DEFAULT      = 64;
   localparam int AMOUNT_WIDTH_DEFAULT = 32;

   // Fixed field widths
   localparam int NUM_RES     = 5;
   localparam int CMD_W       = 2;
   localparam int INDEX_W     = 6;
   localparam int POSITION_W  = 24;
   localparam int AMOUNT_W    = 32;
   localparam int SCORE_W     = 18;
   localparam int COUNT_W     = 7;
   localparam int PM_COUNT_W  = 7;
   localparam int THR_W       = 17;
   localparam int WEIGHT_W    = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;
   localparam int THR_SHIFT   = 16;

   localparam logic [PM_COUNT_W-1:0] PM_COUNT_RESET = 7'd64;
   localparam logic [THR_W-1:0]      THR_RESET      = 17'd32768;
   localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET   = 17'd32768;
   localparam logic [COUNT_W-1:0]    COUNT_SAT      = 7'd127;
   localparam logic [SCORE_W-1:0]    SCORE_SAT      = 18'h3FFFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET_CAPACITY = 2'd0,
      CMD_SET_BASE     = 2'd1,
      CMD_ADD_DEMAND   = 2'd2,
      CMD_EVALUATE     = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PM_COUNT        = 2'd0,
      CSR_UTIL_THRESHOLD  = 2'd1,
      CSR_WEIGHT_ACTIVE   = 2'd2,
      CSR_WEIGHT_OVERLOAD = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_WALK,
      ST_DRAIN,
      ST_MUL,
      ST_DIV_START,
      ST_DIV,
      ST_OUT
   } state_type;

   // Write controls for one resource lane
   typedef struct packed {
      logic cap_we;
      logic base_we;
      logic load_amt_we;
      logic load_sum_we;
      logic load_base_we;
   } lane_cmd_type;

   // Per-machine findings of one resource lane
   typedef struct packed {
      logic over;
      logic nonzero;
   } lane_flags_type;

endpackage

>>> hdl/vpfe_if.sv
interface vpfe_req_if;
   import vpfe_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CMD_W-1:0]       command;
   logic [INDEX_W-1:0]     pm_index;
   logic signed [POSITION_W-1:0] position;
   logic [AMOUNT_W-1:0]    cpu_amount;
   logic [AMOUNT_W-1:0]    ram_amount;
   logic [AMOUNT_W-1:0]    disk_amount;
   logic [AMOUNT_W-1:0]    bandwidth_amount;
   logic [AMOUNT_W-1:0]    fpga_amount;

   modport source (
      output valid, command, pm_index, position, cpu_amount, ram_amount,
             disk_amount, bandwidth_amount, fpga_amount,
      input  ready
   );

   modport sink (
      input  valid, command, pm_index, position, cpu_amount, ram_amount,
             disk_amount, bandwidth_amount, fpga_amount,
      output ready
   );
endinterface

interface vpfe_rsp_if;
   import vpfe_pkg::*;

   logic               valid;
   logic               ready;
   logic [SCORE_W-1:0] score;
   logic [COUNT_W-1:0] active_count;
   logic [COUNT_W-1:0] overloaded_count;

   modport source (
      output valid, score, active_count, overloaded_count,
      input  ready
   );

   modport sink (
      input  valid, score, active_count, overloaded_count,
      output ready
   );
endinterface

>>> hdl/vpfe_lane.sv
module vpfe_lane #(
   parameter int AW    = 32,
   parameter int PA    = 6,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  vpfe_pkg::lane_cmd_type   cmd,
   input  logic [PA-1:0]            rd_addr,
   input  logic [PA-1:0]            wr_addr,
   input  logic [AW-1:0]            wr_amt,
   input  logic [vpfe_pkg::THR_W-1:0] thr,
   output vpfe_pkg::lane_flags_type flags
);
   import vpfe_pkg::*;

   localparam int LW   = AW + 8;
   localparam int PW   = AW + THR_W;
   localparam int CMPW = LW + THR_SHIFT;

   logic [AW-1:0] cap_mem_ff  [DEPTH];
   logic [AW-1:0] base_mem_ff [DEPTH];
   logic [LW-1:0] load_mem_ff [DEPTH];

   logic [AW-1:0] cap_rd_ff;
   logic [AW-1:0] base_rd_ff;
   logic [LW-1:0] load_rd_ff;
   logic [PW-1:0] prod_ff;
   logic [LW-1:0] load_s_ff;

   logic [LW:0]   sum_wide;
   logic [LW-1:0] load_sum;
   logic [LW-1:0] load_wdata;

   // Saturating add of a demand onto the stored load
   assign sum_wide = {1'b0, load_rd_ff} + (LW+1)'(wr_amt);
   assign load_sum = sum_wide[LW] ? {LW{1'b1}} : sum_wide[LW-1:0];

   always_comb begin
      if (cmd.load_base_we) begin
         load_wdata = LW'(base_rd_ff);
      end else if (cmd.load_sum_we) begin
         load_wdata = load_sum;
      end else begin
         load_wdata = LW'(wr_amt);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_we) begin
         cap_mem_ff[wr_addr] <= wr_amt;
      end
      if (cmd.base_we) begin
         base_mem_ff[wr_addr] <= wr_amt;
      end
      if (cmd.load_amt_we || cmd.load_sum_we || cmd.load_base_we) begin
         load_mem_ff[wr_addr] <= load_wdata;
      end
      cap_rd_ff  <= cap_mem_ff[rd_addr];
      base_rd_ff <= base_mem_ff[rd_addr];
      load_rd_ff <= load_mem_ff[rd_addr];
   end

   // Threshold product stage
   always_ff @(posedge clock) begin
      prod_ff   <= PW'(cap_rd_ff) * PW'(thr);
      load_s_ff <= load_rd_ff;
   end

   assign flags.over    = {load_s_ff, {THR_SHIFT{1'b0}}} > CMPW'(prod_ff);
   assign flags.nonzero = |load_s_ff;

endmodule

>>> hdl/vpfe_merge.sv
module vpfe_merge #(
   parameter int CW = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     valid,
   input  vpfe_pkg::lane_flags_type flags [vpfe_pkg::NUM_RES],
   output logic [CW-1:0]            active_count,
   output logic [CW-1:0]            over_count
);
   import vpfe_pkg::*;

   logic [CW-1:0] active_ff, active_in;
   logic [CW-1:0] over_ff, over_in;
   logic          any_over;

   always_comb begin
      any_over = 1'b0;
      for (int r = 0; r < NUM_RES; r++) begin
         any_over = any_over | flags[r].over;
      end
   end

   always_comb begin
      active_in = active_ff;
      over_in   = over_ff;
      if (clear) begin
         active_in = '0;
         over_in   = '0;
      end else if (valid) begin
         active_in = active_ff + CW'(flags[0].nonzero);
         over_in   = over_ff + CW'(any_over);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         over_ff   <= '0;
      end else begin
         active_ff <= active_in;
         over_ff   <= over_in;
      end
   end

   assign active_count = active_ff;
   assign over_count   = over_ff;

endmodule

>>> hdl/vpfe_divider.sv
module vpfe_divider #(
   parameter int NW = 26,
   parameter int DW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);
   localparam int CNTW = $clog2(NW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [NW-1:0]   quo_ff, quo_in;
   logic [DW-1:0]   dvs_ff, dvs_in;
   logic [DW:0]     rem_sh;
   logic            ge;

   // One quotient bit per cycle, restoring
   assign rem_sh = {rem_ff, quo_ff[NW-1]};
   assign ge     = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(NW);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? DW'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DW-1:0];
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hdl/vm_placement_fitness_evaluator.sv
// Scores a candidate VM placement. Five resource lanes (cpu, ram, disk,
// bandwidth, fpga) each hold a capacity, base-load and current-load memory
// of MAX_PMS words; one request transfer carries a command for all five.
// Set capacity and set base load write the lanes on acceptance; add demand
// reads, then does a saturating write-back on the lane's load memory. Evaluate
// walks every machine through the lanes (one machine per cycle, set by the
// single read port of each lane memory) while every load is restored to its
// base and only machines 0..n-1 are counted, then forms the weight products,
// runs the bit-serial divider by n (NW = 18 + clog2(MAX_PMS+1) quotient
// bits) and loads the response register once no earlier response waits;
// n is pm_count clamped to 1..MAX_PMS. The request side is ready only
// between commands; a finished response waits in its own register, so a
// new command may be taken before it is drained. Configuration (pm_count,
// threshold, weights) must be written only while the block is idle. Store
// contents are undefined until written.
module vm_placement_fitness_evaluator #(
   parameter int MAX_PMS      = vpfe_pkg::MAX_PMS_DEFAULT,
   parameter int AMOUNT_WIDTH = vpfe_pkg::AMOUNT_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   vpfe_req_if.sink                         req_ch,
   vpfe_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [vpfe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vpfe_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import vpfe_pkg::*;

   localparam int PA = (MAX_PMS > 1) ? $clog2(MAX_PMS) : 1;
   localparam int CW = $clog2(MAX_PMS + 1);
   localparam int MW = WEIGHT_W + CW;
   localparam int NW = MW + 1;
   localparam int AW = AMOUNT_WIDTH;

   // Configuration registers
   logic [PM_COUNT_W-1:0] pm_count_ff;
   logic [THR_W-1:0]      thr_ff;
   logic [WEIGHT_W-1:0]   w_active_ff;
   logic [WEIGHT_W-1:0]   w_over_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pm_count_ff <= PM_COUNT_RESET;
         thr_ff      <= THR_RESET;
         w_active_ff <= WEIGHT_RESET;
         w_over_ff   <= WEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PM_COUNT:        pm_count_ff <= csr_wdata[PM_COUNT_W-1:0];
            CSR_UTIL_THRESHOLD:  thr_ff      <= csr_wdata[THR_W-1:0];
            CSR_WEIGHT_ACTIVE:   w_active_ff <= csr_wdata[WEIGHT_W-1:0];
            CSR_WEIGHT_OVERLOAD: w_over_ff   <= csr_wdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Machines in use: zero acts as one, anything above MAX_PMS as MAX_PMS
   logic [31:0] pmc32;
   logic [31:0] n32;
   logic [31:0] n_last32;
   logic [CW-1:0] n_cw;

   always_comb begin
      pmc32 = {{(32-PM_COUNT_W){1'b0}}, pm_count_ff};
      if (pmc32 == 32'd0) begin
         n32 = 32'd1;
      end else if (pmc32 > 32'(MAX_PMS)) begin
         n32 = 32'(MAX_PMS);
      end else begin
         n32 = pmc32;
      end
      n_last32 = n32 - 32'd1;
      n_cw     = n32[CW-1:0];
   end

   // Request decode
   logic        req_fire;
   logic        cmd_set_cap;
   logic        cmd_set_base;
   logic        cmd_add;
   logic        cmd_eval;
   logic [31:0] idx32;
   logic        idx_ok;
   logic [PA-1:0] set_addr;
   logic [31:0] pos32;
   logic [PA-1:0] add_addr;
   logic [AW-1:0] req_amt [NUM_RES];
   logic [AMOUNT_W-1:0] req_field [NUM_RES];
   logic [AW+AMOUNT_W-1:0] amt_wide [NUM_RES];

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign cmd_set_cap  = req_ch.command == CMD_SET_CAPACITY;
   assign cmd_set_base = req_ch.command == CMD_SET_BASE;
   assign cmd_add      = req_ch.command == CMD_ADD_DEMAND;
   assign cmd_eval     = req_ch.command == CMD_EVALUATE;

   assign idx32    = {{(32-INDEX_W){1'b0}}, req_ch.pm_index};
   assign idx_ok   = idx32 < 32'(MAX_PMS);
   assign set_addr = idx32[PA-1:0];

   // Round half away from zero (non-negative only), clamp to the last machine
   always_comb begin
      pos32 = 32'd0;
      if (!req_ch.position[POSITION_W-1]) begin
         pos32 = ({{(32-POSITION_W+1){1'b0}}, req_ch.position[POSITION_W-2:0]}
                  + 32'd128) >> 8;
         if (pos32 > n_last32) begin
            pos32 = n_last32;
         end
      end
      add_addr = pos32[PA-1:0];
   end

   assign req_field[0] = req_ch.cpu_amount;
   assign req_field[1] = req_ch.ram_amount;
   assign req_field[2] = req_ch.disk_amount;
   assign req_field[3] = req_ch.bandwidth_amount;
   assign req_field[4] = req_ch.fpga_amount;

   always_comb begin
      for (int r = 0; r < NUM_RES; r++) begin
         amt_wide[r] = {{AW{1'b0}}, req_field[r]};
         req_amt[r]  = amt_wide[r][AW-1:0];
      end
   end

   // Sequencer state
   state_type     state_ff, state_in;
   logic [PA-1:0] walk_addr_ff, walk_addr_in;
   logic [PA-1:0] addr1_ff;
   logic [PA-1:0] add_addr_ff;
   logic          v1_ff;
   logic          v2_ff;
   logic          in_use1_ff;
   logic          in_use2_ff;
   logic [AW-1:0] amt_ff [NUM_RES];
   logic          walk_last;
   logic          merge_clear;
   logic          div_start;
   logic          div_done;
   logic          rsp_load;

   // Walk the whole store so every load goes back to its base
   assign walk_last = 32'(walk_addr_ff) == 32'(MAX_PMS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         walk_addr_ff <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         in_use1_ff   <= 1'b0;
         in_use2_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_addr_ff <= walk_addr_in;
         v1_ff        <= state_ff == ST_WALK;
         v2_ff        <= v1_ff;
         // Count only machines below n
         in_use1_ff   <= (state_ff == ST_WALK) && (32'(walk_addr_ff) < n32);
         in_use2_ff   <= in_use1_ff;
      end
   end

   // Hold the add operands for the write-back cycle
   always_ff @(posedge clock) begin
      addr1_ff <= walk_addr_ff;
      if (req_fire) begin
         add_addr_ff <= add_addr;
         for (int r = 0; r < NUM_RES; r++) begin
            amt_ff[r] <= req_amt[r];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      walk_addr_in = walk_addr_ff;
      merge_clear  = 1'b0;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && cmd_add) begin
               state_in = ST_ADD;
            end else if (req_fire && cmd_eval) begin
               state_in     = ST_WALK;
               walk_addr_in = '0;
               merge_clear  = 1'b1;
            end
         end
         ST_ADD: begin
            state_in = ST_IDLE;
         end
         ST_WALK: begin
            // Advance one machine per cycle
            if (walk_last) begin
               state_in = ST_DRAIN;
            end else begin
               walk_addr_in = walk_addr_ff + PA'(1);
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // Wait for the response register to free up
            if (!rsp_ch.valid || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ch.ready = state_ff == ST_IDLE;

   // Lane controls
   lane_cmd_type   lane_cmd;
   lane_flags_type lane_flags [NUM_RES];
   logic [PA-1:0]  rd_addr;
   logic [PA-1:0]  wr_addr;
   logic [AW-1:0]  wr_amt [NUM_RES];

   always_comb begin
      lane_cmd.cap_we       = req_fire && cmd_set_cap && idx_ok;
      lane_cmd.base_we      = req_fire && cmd_set_base && idx_ok;
      lane_cmd.load_amt_we  = req_fire && cmd_set_base && idx_ok;
      lane_cmd.load_sum_we  = state_ff == ST_ADD;
      lane_cmd.load_base_we = v1_ff;

      rd_addr = (state_ff == ST_IDLE) ? add_addr : walk_addr_ff;

      // Restore write follows the walk read in the next cycle
      if (v1_ff) begin
         wr_addr = addr1_ff;
      end else if (state_ff == ST_ADD) begin
         wr_addr = add_addr_ff;
      end else begin
         wr_addr = set_addr;
      end

      for (int r = 0; r < NUM_RES; r++) begin
         wr_amt[r] = (state_ff == ST_ADD) ? amt_ff[r] : req_amt[r];
      end
   end

   for (genvar g = 0; g < NUM_RES; g++) begin : g_lane
      vpfe_lane #(
         .AW    (AW),
         .PA    (PA),
         .DEPTH (MAX_PMS)
      ) u_lane (
         .clock    (clock),
         .cmd      (lane_cmd),
         .rd_addr  (rd_addr),
         .wr_addr  (wr_addr),
         .wr_amt   (wr_amt[g]),
         .thr      (thr_ff),
         .flags    (lane_flags[g])
      );
   end

   // Merge the lane flags into machine counts
   logic [CW-1:0] active_cnt;
   logic [CW-1:0] over_cnt;

   vpfe_merge #(
      .CW (CW)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .clear        (merge_clear),
      .valid        (in_use2_ff),
      .flags        (lane_flags),
      .active_count (active_cnt),
      .over_count   (over_cnt)
   );

   // Weighted sum, then divide by the machine count
   logic [MW-1:0] prod_active_ff;
   logic [MW-1:0] prod_over_ff;
   logic [NW-1:0] quotient;

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_active_ff <= MW'(w_active_ff) * MW'(active_cnt);
         prod_over_ff   <= MW'(w_over_ff) * MW'(over_cnt);
      end
   end

   vpfe_divider #(
      .NW (NW),
      .DW (CW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (NW'(prod_active_ff) + NW'(prod_over_ff)),
      .divisor  (n_cw),
      .done     (div_done),
      .quotient (quotient)
   );

   // Response register
   logic               rsp_valid_ff;
   logic [SCORE_W-1:0] score_ff;
   logic [COUNT_W-1:0] active_out_ff;
   logic [COUNT_W-1:0] over_out_ff;
   logic [31:0]        active32;
   logic [31:0]        over32;

   assign active32 = 32'(active_cnt);
   assign over32   = 32'(over_cnt);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         score_ff      <= (|quotient[NW-1:SCORE_W]) ? SCORE_SAT
                                                    : quotient[SCORE_W-1:0];
         active_out_ff <= (active32 > 32'(COUNT_SAT)) ? COUNT_SAT
                                                      : active32[COUNT_W-1:0];
         over_out_ff   <= (over32 > 32'(COUNT_SAT)) ? COUNT_SAT
                                                    : over32[COUNT_W-1:0];
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.score            = score_ff;
   assign rsp_ch.active_count     = active_out_ff;
   assign rsp_ch.overloaded_count = over_out_ff;

   // Checks
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> 32'(walk_addr_ff) < 32'(MAX_PMS))
      else $error("walk address beyond the machine store");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside its wait state");

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> (active32 <= n32) && (over32 <= n32))
      else $error("machine counts exceed machines in use");

   a_eval_starts_walk: assert property (@(posedge clock) disable iff (reset)
      req_fire && cmd_eval |=> state_ff == ST_WALK && walk_addr_ff == '0)
      else $error("evaluate did not start the walk at machine zero");

endmodule

>>> verif/vm_placement_fitness_evaluator_tb.sv
`timescale 1ns / 1ps

module vm_placement_fitness_evaluator_tb;
   import vpfe_pkg::*;

   localparam int MACHINES      = MAX_PMS_DEFAULT;
   localparam int LOAD_W        = AMOUNT_W + 8;
   // Leave plenty of margin past the longest evaluate
   localparam int SETTLE_CYCLES = 150;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int MAX_REPORTS   = 200;

   localparam logic [LOAD_W-1:0] LOAD_SAT = '1;

   // One request transfer: amount[0] is cpu, then ram, disk, bandwidth, fpga
   typedef struct packed {
      cmd_type                          command;
      logic [INDEX_W-1:0]               pm_index;
      logic [POSITION_W-1:0]            position;
      logic [NUM_RES-1:0][AMOUNT_W-1:0] amount;
   } placement_cmd_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [COUNT_W-1:0] active;
      logic [COUNT_W-1:0] overloaded;
   } fitness_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   csr_index_type         csr_index = CSR_PM_COUNT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Request side is driven from these; response ready likewise
   logic              cmd_valid  = 1'b0;
   placement_cmd_type cmd_on_bus = '0;
   logic              rsp_ready  = 1'b0;

   // Predictor copy of the machine stores and the configuration
   logic [AMOUNT_W-1:0]   cap_words  [MACHINES][NUM_RES];
   logic [AMOUNT_W-1:0]   base_words [MACHINES][NUM_RES];
   logic [LOAD_W-1:0]     load_words [MACHINES][NUM_RES];
   logic [PM_COUNT_W-1:0] pm_count_cfg  = PM_COUNT_RESET;
   logic [THR_W-1:0]      threshold_cfg = THR_RESET;
   logic [WEIGHT_W-1:0]   w_active_cfg  = WEIGHT_RESET;
   logic [WEIGHT_W-1:0]   w_over_cfg    = WEIGHT_RESET;

   placement_cmd_type cmd_queue[$];
   fitness_type       expected_fitness[$];

   int          error_count        = 0;
   int unsigned cycle_count        = 0;
   int          sender_idle_pct    = 0;
   int          receiver_stall_pct = 0;

   vpfe_req_if req_ch ();
   vpfe_rsp_if rsp_ch ();

   assign req_ch.valid            = cmd_valid;
   assign req_ch.command          = cmd_on_bus.command;
   assign req_ch.pm_index         = cmd_on_bus.pm_index;
   assign req_ch.position         = cmd_on_bus.position;
   assign req_ch.cpu_amount       = cmd_on_bus.amount[0];
   assign req_ch.ram_amount       = cmd_on_bus.amount[1];
   assign req_ch.disk_amount      = cmd_on_bus.amount[2];
   assign req_ch.bandwidth_amount = cmd_on_bus.amount[3];
   assign req_ch.fpga_amount      = cmd_on_bus.amount[4];
   assign rsp_ch.ready            = rsp_ready;

   vm_placement_fitness_evaluator dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Fitness predictor
   // ---------------------------------------------------------------------

   // Zero machines acts as one, anything past the store size as the full store
   function automatic int unsigned machines_in_use(logic [PM_COUNT_W-1:0] cfg);
      if (cfg == 0) return 1;
      if (cfg > MACHINES) return MACHINES;
      return cfg;
   endfunction

   // load / capacity > threshold, cross-multiplied so zero capacity means load > 0
   function automatic bit over_threshold(logic [LOAD_W-1:0] load, logic [AMOUNT_W-1:0] cap);
      logic [63:0] lhs;
      logic [63:0] rhs;
      lhs = 64'(load) << THR_SHIFT;
      rhs = 64'(cap) * 64'(threshold_cfg);
      return lhs > rhs;
   endfunction

   // Apply one accepted transfer to the predictor; evaluate queues a fitness
   task automatic predict_fitness(placement_cmd_type c);
      int unsigned     n;
      int unsigned     target;
      int unsigned     active;
      int unsigned     over;
      logic [31:0]     weighted;
      logic [LOAD_W:0] sum;
      bit              hot;
      fitness_type     res;
      n = machines_in_use(pm_count_cfg);
      case (c.command)
         CMD_SET_CAPACITY: begin
            for (int r = 0; r < NUM_RES; r++) cap_words[c.pm_index][r] = c.amount[r];
         end
         CMD_SET_BASE: begin
            // a base write also drops whatever demand landed there since evaluate
            for (int r = 0; r < NUM_RES; r++) begin
               base_words[c.pm_index][r] = c.amount[r];
               load_words[c.pm_index][r] = LOAD_W'(c.amount[r]);
            end
         end
         CMD_ADD_DEMAND: begin
            // round half away from zero; any negative coordinate lands on machine 0
            target = 0;
            if (!c.position[POSITION_W-1]) begin
               target = (32'(c.position) + 32'd128) >> 8;
               if (target > n - 1) target = n - 1;
            end
            for (int r = 0; r < NUM_RES; r++) begin
               sum = {1'b0, load_words[target][r]} + {9'b0, c.amount[r]};
               load_words[target][r] = (sum > {1'b0, LOAD_SAT}) ? LOAD_SAT : sum[LOAD_W-1:0];
            end
         end
         default: begin
            active = 0;
            over   = 0;
            for (int m = 0; m < n; m++) begin
               hot = 1'b0;
               if (load_words[m][0] != 0) active++;
               for (int r = 0; r < NUM_RES; r++)
                  if (over_threshold(load_words[m][r], cap_words[m][r])) hot = 1'b1;
               if (hot) over++;
            end
            weighted       = (w_active_cfg * active + w_over_cfg * over) / n;
            res.score      = (weighted > SCORE_SAT) ? SCORE_SAT : SCORE_W'(weighted);
            res.active     = (active > COUNT_SAT) ? COUNT_SAT : COUNT_W'(active);
            res.overloaded = (over > COUNT_SAT) ? COUNT_SAT : COUNT_W'(over);
            expected_fitness.insert(expected_fitness.size(), res);
            // every machine goes back to its base load, in use or not
            for (int m = 0; m < MACHINES; m++)
               for (int r = 0; r < NUM_RES; r++) load_words[m][r] = LOAD_W'(base_words[m][r]);
         end
      endcase
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      if (error_count < MAX_REPORTS)
         $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Request driver: advance to the next queued command once the bus is free
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      if (reset) begin
         cmd_valid <= 1'b0;
      end else begin
         if (cmd_valid && req_ch.ready) begin
            predict_fitness(cmd_on_bus);
         end
         if (!cmd_valid || req_ch.ready) begin
            // hold the bus idle on a random gap, otherwise present the next command
            if (cmd_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               cmd_valid  <= 1'b1;
               cmd_on_bus <= cmd_queue.pop_front();
            end else begin
               cmd_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: compare each transfer with the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : response_monitor
      fitness_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ready) begin
            if (expected_fitness.size() == 0) begin
               report_mismatch("response with none pending, score", rsp_ch.score, 0);
            end else begin
               want = expected_fitness.pop_front();
               if (rsp_ch.score !== want.score)
                  report_mismatch("score", rsp_ch.score, want.score);
               if (rsp_ch.active_count !== want.active)
                  report_mismatch("active_count", rsp_ch.active_count, want.active);
               if (rsp_ch.overloaded_count !== want.overloaded)
                  report_mismatch("overloaded_count", rsp_ch.overloaded_count,
                                  want.overloaded);
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Drop the run if it hangs
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Mostly moderate values, with zero, all ones and full-range words mixed in
   function automatic logic [AMOUNT_W-1:0] pick_amount(int unsigned typical);
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         2:       return AMOUNT_W'($urandom);
         default: return AMOUNT_W'($urandom_range(typical));
      endcase
   endfunction

   function automatic placement_cmd_type make_cmd(cmd_type op, int unsigned idx, int pos,
                                                  int unsigned typical);
      placement_cmd_type c;
      c.command  = op;
      c.pm_index = INDEX_W'(idx);
      c.position = POSITION_W'(pos);
      for (int r = 0; r < NUM_RES; r++) c.amount[r] = pick_amount(typical);
      // an idle cpu keeps the machine out of the active count until demand lands on it
      if (op == CMD_SET_BASE && $urandom_range(1) == 0) c.amount[0] = '0;
      return c;
   endfunction

   // Coordinate near a machine center, sometimes past the clamp
   function automatic int aim_position(int unsigned n_pms);
      int unsigned pm;
      if ($urandom_range(7) == 0) pm = $urandom_range(32767);
      else pm = $urandom_range(n_pms);
      return int'(pm * 256) + int'($urandom_range(255)) - 128;
   endfunction

   // Append one command to the end of the pending queue
   task automatic enqueue_cmd(placement_cmd_type c);
      cmd_queue.insert(cmd_queue.size(), c);
   endtask

   // Write capacity and base load of every machine so no store is read unwritten
   task automatic queue_machine_setup();
      for (int m = 0; m < MACHINES; m++) begin
         enqueue_cmd(make_cmd(CMD_SET_CAPACITY, m, 0, 4000));
         enqueue_cmd(make_cmd(CMD_SET_BASE, m, 0, 400));
      end
   endtask

   task automatic queue_directed();
      int                spots[9] = '{'h000000, 'h00007F, 'h000080, 'h00017F, 'h000180,
                                      'h003F80, 'h7FFFFF, 'h800000, 'hFFFFFF};
      placement_cmd_type c;
      enqueue_cmd(make_cmd(CMD_EVALUATE, 0, 0, 0));
      // rounding at the half points, clamp at the top, negative coordinates
      foreach (spots[i]) begin
         c = make_cmd(CMD_ADD_DEMAND, 0, spots[i], 0);
         c.amount = '1;
         enqueue_cmd(c);
      end
      enqueue_cmd(make_cmd(CMD_EVALUATE, 63, 0, 0));
      // base write throws away the demand just placed on machine 5
      enqueue_cmd(make_cmd(CMD_ADD_DEMAND, 0, 5 * 256, 3000));
      enqueue_cmd(make_cmd(CMD_SET_BASE, 5, 0, 100));
      // zero capacity counts as overloaded on any load
      c = make_cmd(CMD_SET_CAPACITY, 7, 0, 0);
      c.amount = '0;
      enqueue_cmd(c);
      c = make_cmd(CMD_ADD_DEMAND, 0, 7 * 256, 0);
      c.amount = '0;
      c.amount[1] = 1;
      enqueue_cmd(c);
      // all-ones capacity and base on the last machine
      c = make_cmd(CMD_SET_CAPACITY, 63, 0, 0);
      c.amount = '1;
      enqueue_cmd(c);
      c = make_cmd(CMD_SET_BASE, 63, 0, 0);
      c.amount = '1;
      enqueue_cmd(c);
      enqueue_cmd(make_cmd(CMD_EVALUATE, 0, -1, 0));
   endtask

   // Mostly placements followed by evaluate; the rest store updates and noise
   task automatic queue_random_cmds(int unsigned n_items, int unsigned n_pms);
      int unsigned made;
      int unsigned adds;
      int unsigned pick;
      made = 0;
      while (made < n_items) begin
         pick = $urandom_range(19);
         if (pick < 15) begin
            adds = $urandom_range(1, 12);
            repeat (adds)
               enqueue_cmd(make_cmd(CMD_ADD_DEMAND, $urandom_range(63),
                                    aim_position(n_pms), 1500));
            enqueue_cmd(make_cmd(CMD_EVALUATE, $urandom_range(63),
                                 int'($urandom), 1500));
            made += adds + 1;
         end else if (pick < 17) begin
            enqueue_cmd(make_cmd(CMD_SET_BASE, $urandom_range(63), 0, 400));
            made++;
         end else if (pick < 18) begin
            enqueue_cmd(make_cmd(CMD_SET_CAPACITY, $urandom_range(63), 0, 4000));
            made++;
         end else begin
            enqueue_cmd(make_cmd(cmd_type'($urandom_range(3)), $urandom_range(63),
                                 int'($urandom), 32'hFFFF_FFFF));
            made++;
         end
      end
   endtask

   // Pile enough all-ones demand on one machine to hit the load ceiling
   task automatic queue_load_saturation();
      placement_cmd_type c;
      c = make_cmd(CMD_SET_BASE, 0, 0, 0);
      c.amount = '1;
      enqueue_cmd(c);
      repeat (260) begin
         c = make_cmd(CMD_ADD_DEMAND, 0, int'($urandom), 0);
         c.amount = '1;
         enqueue_cmd(c);
      end
      enqueue_cmd(make_cmd(CMD_EVALUATE, 0, 0, 0));
      queue_random_cmds(20, 1);
   endtask

   // Hold until every command is accepted and answered, then let the block settle
   task automatic wait_until_drained();
      do @(negedge clock);
      while (cmd_queue.size() != 0 || cmd_valid || expected_fitness.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_PM_COUNT:       pm_count_cfg  = value[PM_COUNT_W-1:0];
         CSR_UTIL_THRESHOLD: threshold_cfg = value[THR_W-1:0];
         CSR_WEIGHT_ACTIVE:  w_active_cfg  = value[WEIGHT_W-1:0];
         default:            w_over_cfg    = value[WEIGHT_W-1:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(logic [PM_COUNT_W-1:0] pms, logic [THR_W-1:0] thr,
                            logic [WEIGHT_W-1:0] wa, logic [WEIGHT_W-1:0] wo,
                            int idle_pct, int stall_pct, int unsigned n_items);
      write_csr(CSR_PM_COUNT, CSR_DATA_W'(pms));
      write_csr(CSR_UTIL_THRESHOLD, thr);
      write_csr(CSR_WEIGHT_ACTIVE, wa);
      write_csr(CSR_WEIGHT_OVERLOAD, wo);
      @(negedge clock);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      queue_random_cmds(n_items, machines_in_use(pms));
      wait_until_drained();
   endtask

   initial begin
      for (int m = 0; m < MACHINES; m++)
         for (int r = 0; r < NUM_RES; r++) begin
            cap_words[m][r]  = '0;
            base_words[m][r] = '0;
            load_words[m][r] = '0;
         end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration: fill the stores, then the directed cases
      queue_machine_setup();
      queue_directed();
      wait_until_drained();

      // random placements under a range of settings and idle patterns
      run_phase(7'd64, 17'd32768, 17'd32768, 17'd32768, 0, 0, 60);
      run_phase(7'd1, 17'd65536, 17'd65536, 17'd65536, 58, 0, 60);
      run_phase(7'd0, 17'd0, 17'd131071, 17'd131071, 0, 58, 60);
      run_phase(7'd127, 17'd131071, 17'd0, 17'd65536, 31, 31, 60);
      run_phase(7'd17, 17'd49152, WEIGHT_W'($urandom), WEIGHT_W'($urandom), 0, 0, 60);
      run_phase(7'd64, 17'd1, 17'd1, 17'd131071, 58, 0, 60);
      run_phase(7'd33, 17'd65535, 17'd65535, 17'd0, 0, 58, 60);
      run_phase(7'd8, 17'd16384, 17'd20000, 17'd50000, 31, 31, 60);

      // single machine so every add lands on it until the load word saturates
      write_csr(CSR_PM_COUNT, CSR_DATA_W'(1));
      @(negedge clock);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      queue_load_saturation();
      wait_until_drained();

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/vpfe_pkg.sv
hdl/vpfe_if.sv
hdl/vpfe_lane.sv
hdl/vpfe_merge.sv
hdl/vpfe_divider.sv
hdl/vm_placement_fitness_evaluator.sv
verif/vm_placement_fitness_evaluator_tb.sv
